[design/q8r_pkg.sv]
// Package: shared types and constants for the Q8 block to affine repacker.
`default_nettype none
package q8r_pkg;
    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;
    localparam logic KIND_SCALE = 1'b0;
    localparam logic KIND_WORD  = 1'b1;
    localparam logic [7:0] EXP_BIAS_DIFF = 8'd112;  // 127 - 15
    localparam logic [7:0] EXP_ALL_ONES  = 8'hFF;
    localparam logic [4:0] HALF_EXP_MAX  = 5'h1F;
    localparam logic [7:0] BIAS_EXP_STEP = 8'd7;    // log2 of 128

    // output item tdata: scale_bits, bias_bits, packed_word (96 bits)
    typedef struct packed {
        logic [31:0] packed_word;
        logic [31:0] bias_bits;
        logic [31:0] scale_bits;
    } out_data_t;

    // half precision to single precision, exact
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic        sgn;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  lz;
        logic [9:0]  mn;
        logic [7:0]  e32;
        logic [31:0] r;
        sgn = h[15];
        ex  = h[14:10];
        man = h[9:0];
        lz  = 4'd0;
        // priority encode the leading one of the mantissa
        for (int i = 0; i < 10; i++) begin
            if (man[i])
            begin
                lz = 4'(9 - i);
            end
        end
        mn  = 10'(man << (lz + 4'd1));
        e32 = 8'(EXP_BIAS_DIFF - 8'(lz));
        if (ex == 5'd0) begin
            if (man == 10'd0)
                r = {sgn, 31'd0};
            else
                r = {sgn, e32, mn, 13'd0};
        end else if (ex == HALF_EXP_MAX) begin
            r = {sgn, EXP_ALL_ONES, man, 13'd0};
        end else begin
            r = {sgn, 8'(8'(ex) + EXP_BIAS_DIFF), man, 13'd0};
        end
        return r;
    endfunction

    // minus 128 times a single: flip sign, raise exponent by 7 when the exponent field is neither zero nor all ones
    function automatic logic [31:0] bias_of(input logic [31:0] f);
        logic [31:0] r;
        r = {~f[31], f[30:0]};
        if (f[30:23] != 8'd0 && f[30:23] != EXP_ALL_ONES)
            r[30:23] = f[30:23] + BIAS_EXP_STEP;
        return r;
    endfunction
endpackage
`default_nettype wire

[design/q8_block_to_affine_repacker.sv]
// Top level: Q8 block byte stream to affine uint8 repacked words.
//
// Channel   Dir  tdata                                    tuser        tlast
// s_axis    in   byte_in[7:0]                             -            -
// m_axis    out  scale_bits, bias_bits, packed_word (96)  kind         end_of_block
//
// One byte enters per cycle unless stalled; each result is registered and
// appears in the cycle after the byte that completes it, from a single output
// register. The header decode and quant packing are one pass of logic per
// byte. Reset clears the byte position and the output valid. A stall on m_axis
// holds the input only while the output register is full and not being taken.
`default_nettype none
module q8_block_to_affine_repacker #(
    parameter int BLOCK_QUANTS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // byte_in[7:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // scale_bits, bias_bits, packed_word
    output logic             m_axis_tuser,   // kind
    output logic             m_axis_tlast    // end_of_block
);
    import q8r_pkg::*;

    localparam int POS_W = $clog2(BLOCK_QUANTS + 2);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       low_reg, low_next;
    logic [23:0]      acc_reg, acc_next;
    logic             ov_reg, ov_next;
    out_data_t        od_reg, od_next;
    logic             kind_reg, kind_next;
    logic             last_reg, last_next;

    logic             take;
    logic [POS_W-1:0] q;
    logic [1:0]       lane;
    logic             blk_last;
    logic [31:0]      word;
    logic [31:0]      scale;
    logic             emit;

    assign s_axis_tready = !ov_reg || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign q             = pos_reg - POS_W'(2);
    assign lane          = q[1:0];
    assign blk_last      = (q + POS_W'(1)) >= POS_W'(BLOCK_QUANTS);
    assign word          = {8'd0, acc_reg} | (32'(s_axis_tdata ^ 8'h80) << {lane, 3'd0});
    assign scale         = half_to_single({s_axis_tdata, low_reg});

    // decode one byte and form the result
    always_comb
    begin
        pos_next  = pos_reg;
        low_next  = low_reg;
        acc_next  = acc_reg;
        od_next   = od_reg;
        kind_next = kind_reg;
        last_next = last_reg;
        emit      = 1'b0;
        if (take)
        begin
            if (pos_reg == POS_W'(0))
            begin
                low_next = s_axis_tdata;
                pos_next = POS_W'(1);
            end
            else if (pos_reg == POS_W'(1))
            begin
                emit      = 1'b1;
                kind_next = KIND_SCALE;
                last_next = 1'b0;
                od_next   = '{packed_word: 32'd0, bias_bits: bias_of(scale),
                              scale_bits: scale};
                acc_next  = 24'd0;
                pos_next  = POS_W'(2);
            end
            else
            begin
                pos_next = blk_last ? POS_W'(0) : pos_reg + POS_W'(1);
                if (lane == 2'd3 || blk_last)
                begin
                    emit      = 1'b1;
                    kind_next = KIND_WORD;
                    last_next = blk_last;
                    od_next   = '{packed_word: word, bias_bits: 32'd0, scale_bits: 32'd0};
                    acc_next  = 24'd0;
                end
                else
                begin
                    acc_next = word[23:0];
                end
            end
        end
        // advance output register
        if (emit)
            ov_next = 1'b1;
        else if (m_axis_tready)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            low_reg <= '0;
            acc_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            low_reg <= low_next;
            acc_reg <= acc_next;
            ov_reg  <= ov_next;
        end
    end

    // hold result payload
    always_ff @(posedge clk)
    begin
        od_reg   <= od_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;
endmodule
`default_nettype wire
